// ----- src/vn_pkg.sv -----
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths and the pipeline payload type for the vector normaliser.
// ----------------------------------------------------------------------------
`default_nettype none
package vn_pkg;

    localparam int COMP_W  = 16;
    localparam int SQ_W    = 31;
    localparam int SUM_W   = 32;
    localparam int ROOT_W  = 16;
    localparam int REM_W   = 34;
    localparam int Q_W     = 15;
    localparam int ACC_W   = 66;
    localparam int N_COMP  = 3;
    localparam int N_ITER  = 16;
    localparam int TDATA_W = 64;
    localparam int SDATA_W = 48;

    typedef struct packed {
        logic                                valid;
        logic                                planar;
        logic [COMP_W-1:0]                   zraw;
        logic [N_COMP-1:0]                   neg;
        logic [SUM_W-1:0]                    s;
        logic [ROOT_W-1:0]                   root;
        logic [REM_W-1:0]                    rem;
        logic [N_COMP-1:0][Q_W-1:0]          q;
        logic [N_COMP-1:0][ACC_W-1:0]        w;
        logic [N_COMP-1:0][ACC_W-1:0]        e;
    } t_pipe;

endpackage
`default_nettype wire

// ----- src/vector_normalize.sv -----
// ----------------------------------------------------------------------------
// vector_normalize
// Length and Q1.14 unit vector of a signed 16-bit 3-vector, optionally planar.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: comp_x, comp_y, comp_z
// m_axis    out        tdata: unit_x, unit_y, unit_z, length; tuser: is_zero
// cfg       in         planar_mode, written when i_cfg_wr_en is high
//
// One beat is accepted every cycle unless stalled. Stages: two squaring and
// summing stages, sixteen bit stages of the root and quotient search, and
// the output register. Reset is synchronous and clears only valid flags and
// the mode. A stall at the output freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
`default_nettype none
module vector_normalize (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic                         i_cfg_wr_data,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    // comp_x [15:0], comp_y [31:16], comp_z [47:32]
    input  wire logic [vn_pkg::SDATA_W-1:0]   i_s_tdata,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    // unit_x [15:0], unit_y [31:16], unit_z [47:32], length [63:48]
    output logic [vn_pkg::TDATA_W-1:0]        o_m_tdata,
    // is_zero [0]
    output logic                              o_m_tuser
);

    logic          r_planar;
    logic          en;
    vn_pkg::t_pipe pipe [vn_pkg::N_ITER+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planar <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_planar <= i_cfg_wr_data;
        end
    end

    assign o_s_tready = en;

    vn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_tvalid),
        .i_planar (r_planar),
        .i_data   (i_s_tdata),
        .o_pipe   (pipe[0])
    );

    for (genvar n = 0; n < vn_pkg::N_ITER; n++) begin : g_iter
        vn_iter #(.B(vn_pkg::N_ITER - 1 - n)) u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_pipe  (pipe[n]),
            .o_pipe  (pipe[n+1])
        );
    end

    vn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_m_tready (i_m_tready),
        .i_pipe     (pipe[vn_pkg::N_ITER]),
        .o_en       (en),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef SYNTHESIS
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");
    a_zero_clears_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[63:48] == 16'd0
                                       && o_m_tdata[15:0] == 16'd0))
        else $error("zero vector with nonzero length or x");
    a_nonzero_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[63:48] != 16'd0))
        else $error("nonzero vector with zero length");
`endif

endmodule
`default_nettype wire

// ----- src/vn_front.sv -----
// ----------------------------------------------------------------------------
// vn_front
// Squares the components, forms the sum of squares and seeds the search state.
// ----------------------------------------------------------------------------
`default_nettype none
module vn_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic                          i_planar,
    input  wire logic [vn_pkg::SDATA_W-1:0]    i_data,
    output vn_pkg::t_pipe                      o_pipe
);

    logic                                              r_valid1;
    logic                                              r_planar1;
    logic [vn_pkg::COMP_W-1:0]                         r_zraw1;
    logic [vn_pkg::N_COMP-1:0]                         r_neg1;
    logic [vn_pkg::N_COMP-1:0][vn_pkg::SQ_W-1:0]       r_sq1;
    logic [vn_pkg::N_COMP-1:0][vn_pkg::SQ_W-1:0]       n_sq1;
    logic [vn_pkg::N_COMP-1:0]                         n_neg1;
    vn_pkg::t_pipe                                     r_pipe;
    vn_pkg::t_pipe                                     n_pipe;

    always_comb begin
        logic signed [vn_pkg::COMP_W-1:0] c;
        logic        [vn_pkg::COMP_W-1:0] a;
        for (int i = 0; i < vn_pkg::N_COMP; i++) begin
            c = $signed(i_data[i*vn_pkg::COMP_W +: vn_pkg::COMP_W]);
            a = c[vn_pkg::COMP_W-1] ? vn_pkg::COMP_W'(-c) : vn_pkg::COMP_W'(c);
            n_neg1[i] = c[vn_pkg::COMP_W-1];
            n_sq1[i]  = vn_pkg::SQ_W'(32'(a) * 32'(a));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else if (i_en) begin
            r_valid1  <= i_valid;
            r_planar1 <= i_planar;
            r_zraw1   <= i_data[2*vn_pkg::COMP_W +: vn_pkg::COMP_W];
            r_neg1    <= n_neg1;
            r_sq1     <= n_sq1;
        end
    end

    always_comb begin
        logic [vn_pkg::SUM_W-1:0] s;
        s = vn_pkg::SUM_W'(r_sq1[0]) + vn_pkg::SUM_W'(r_sq1[1])
            + (r_planar1 ? '0 : vn_pkg::SUM_W'(r_sq1[2]));
        n_pipe.valid  = r_valid1;
        n_pipe.planar = r_planar1;
        n_pipe.zraw   = r_zraw1;
        n_pipe.neg    = r_neg1;
        n_pipe.s      = s;
        n_pipe.root   = '0;
        n_pipe.rem    = vn_pkg::REM_W'(s);
        for (int i = 0; i < vn_pkg::N_COMP; i++) begin
            n_pipe.q[i] = '0;
            n_pipe.w[i] = vn_pkg::ACC_W'(-$signed({2'b00, s}));
            n_pipe.e[i] = {5'b0, r_sq1[i], 30'b0} - vn_pkg::ACC_W'(s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule
`default_nettype wire

// ----- src/vn_iter.sv -----
// ----------------------------------------------------------------------------
// vn_iter
// One root bit and, for B < Q_W, one quotient bit of each scaled component.
// ----------------------------------------------------------------------------
`default_nettype none
module vn_iter #(
    parameter int B = 15
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire vn_pkg::t_pipe i_pipe,
    output vn_pkg::t_pipe o_pipe
);

    vn_pkg::t_pipe r_pipe;
    vn_pkg::t_pipe n_pipe;

    always_comb begin
        logic [vn_pkg::REM_W-1:0]        trial;
        logic signed [vn_pkg::ACC_W-1:0] ss;
        logic signed [vn_pkg::ACC_W-1:0] d;
        n_pipe = i_pipe;
        trial  = ({(vn_pkg::REM_W-vn_pkg::ROOT_W-1)'(0), i_pipe.root, 1'b0}
                  + (vn_pkg::REM_W'(1) << B)) << B;
        if (trial <= i_pipe.rem) begin
            n_pipe.rem  = i_pipe.rem - trial;
            n_pipe.root = i_pipe.root | (vn_pkg::ROOT_W'(1) << B);
        end
        ss = $signed({(vn_pkg::ACC_W-vn_pkg::SUM_W)'(0), i_pipe.s});
        for (int i = 0; i < vn_pkg::N_COMP; i++) begin
            d = ($signed(i_pipe.w[i]) <<< (B + 2)) + (ss <<< (2*B + 2));
            if (B < vn_pkg::Q_W && d <= $signed(i_pipe.e[i])) begin
                n_pipe.e[i] = i_pipe.e[i] - d;
                n_pipe.w[i] = i_pipe.w[i] + (ss <<< (B + 1));
                n_pipe.q[i] = i_pipe.q[i] | vn_pkg::Q_W'(1 << B);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule
`default_nettype wire

// ----- src/vn_back.sv -----
// ----------------------------------------------------------------------------
// vn_back
// Rounds the length, applies signs and the zero case, and holds the output beat.
// ----------------------------------------------------------------------------
`default_nettype none
module vn_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_m_tready,
    input  wire vn_pkg::t_pipe                 i_pipe,
    output logic                               o_en,
    output logic                               o_m_tvalid,
    output logic [vn_pkg::TDATA_W-1:0]         o_m_tdata,
    output logic                               o_m_tuser
);

    logic                          r_valid;
    logic [vn_pkg::TDATA_W-1:0]    r_data;
    logic                          r_user;
    logic [vn_pkg::TDATA_W-1:0]    n_data;
    logic                          n_user;

    assign o_en = !r_valid || i_m_tready;

    always_comb begin
        logic [vn_pkg::COMP_W-1:0] u;
        logic [vn_pkg::ROOT_W-1:0] len;
        n_user = (i_pipe.s == '0);
        len = i_pipe.root
              + vn_pkg::ROOT_W'(i_pipe.rem > vn_pkg::REM_W'(i_pipe.root));
        for (int i = 0; i < vn_pkg::N_COMP; i++) begin
            u = {1'b0, i_pipe.q[i]};
            if (i_pipe.neg[i]) begin
                u = -u;
            end
            n_data[i*vn_pkg::COMP_W +: vn_pkg::COMP_W] = n_user ? '0 : u;
        end
        if (i_pipe.planar) begin
            n_data[2*vn_pkg::COMP_W +: vn_pkg::COMP_W] = i_pipe.zraw;
        end
        n_data[3*vn_pkg::COMP_W +: vn_pkg::COMP_W] = n_user ? '0 : len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_pipe.valid;
            r_data  <= n_data;
            r_user  <= n_user;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;

endmodule
`default_nettype wire
